// ----- rtl/core/wcau_pkg.sv -----
package wcau_pkg;

    // Fixed widths of the sample path and of the coefficient.
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int LEN_BITS    = 13;
    localparam int POS_BITS    = 12;
    localparam int MAX_FRAME   = 4096;
    localparam int MIN_FRAME   = 2;
    localparam int COS_DEPTH   = 1024;
    localparam int COS_ABITS   = 11;
    localparam int COS_DBITS   = 17;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_LEN   = 2'd1;
    localparam logic [1:0] CFG_ALPHA = 2'd2;

    // Window kind codes; codes above KIND_FLAT are invalid.
    localparam logic [3:0] KIND_HANN     = 4'd0;
    localparam logic [3:0] KIND_HAMMING  = 4'd1;
    localparam logic [3:0] KIND_GENCOS   = 4'd2;
    localparam logic [3:0] KIND_BLACKMAN = 4'd3;
    localparam logic [3:0] KIND_TRI_ZERO = 4'd4;
    localparam logic [3:0] KIND_TRI_NZ   = 4'd5;
    localparam logic [3:0] KIND_BHARRIS  = 4'd6;
    localparam logic [3:0] KIND_RECT     = 4'd7;
    localparam logic [3:0] KIND_FLAT     = 4'd8;

    // Reset values of the registers and of the derived state.
    localparam logic [3:0]                  RST_KIND  = KIND_HANN;
    localparam logic [LEN_BITS-1:0]         RST_LEN   = 13'd1024;
    localparam logic signed [COEF_BITS-1:0] RST_ALPHA = 18'sd35389;
    localparam logic [31:0]                 RST_STEP  = 32'd4194304;
    localparam logic [COEF_BITS-1:0]        RST_SLOPE = 18'd128;

    // Window constants in Q16.
    localparam logic signed [19:0] Q_ONE       = 20'sd65536;
    localparam logic signed [19:0] Q_HALF      = 20'sd32768;
    localparam logic signed [19:0] Q_HAM_A0    = 20'sd35282;
    localparam logic signed [19:0] Q_HAM_A1    = 20'sd30254;
    localparam logic signed [19:0] Q_BLK_A0    = 20'sd27525;
    localparam logic signed [19:0] Q_BLK_A2    = 20'sd5243;
    localparam logic signed [19:0] Q_BH_A0     = 20'sd23511;
    localparam logic signed [19:0] Q_BH_A1     = 20'sd32001;
    localparam logic signed [19:0] Q_BH_A2     = 20'sd9259;
    localparam logic signed [19:0] Q_BH_A3     = 20'sd765;
    localparam logic signed [19:0] Q_FT_A0     = 20'sd18420;
    localparam logic signed [19:0] Q_FT_A1     = 20'sd34138;
    localparam logic signed [19:0] Q_FT_A2     = 20'sd12979;

    // Triangle region of a position within the frame.
    typedef enum logic [1:0] {
        TRI_RISE = 2'd0,
        TRI_FALL = 2'd1,
        TRI_ZERO = 2'd2
    } tri_region_t;

    // One word held in the queue between front and back end.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [31:0]                   phase;
        logic [LEN_BITS-1:0]           tri_mul;
        tri_region_t                   tri_region;
        logic                          frame_end;
    } item_t;

    // Configuration state shared by the front and back ends.
    typedef struct packed {
        logic [3:0]                  kind;
        logic [LEN_BITS-1:0]         len;
        logic signed [COEF_BITS-1:0] alpha;
        logic [31:0]                 step;
        logic [COEF_BITS-1:0]        slope;
        logic                        busy;
        logic                        restart;
    } cfg_state_t;

    // Quarter-wave cosine table in Q16, built at elaboration.
    typedef logic [COS_DBITS-1:0] cos_rom_t [0:COS_DEPTH];
    typedef longint unsigned series_t [0:6];

    localparam series_t SERIES_DIV = '{182, 132, 90, 56, 30, 12, 2};
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE    = 64'd1073741824;

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t        rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned p;
        longint unsigned d;
        for (int k = 0; k <= COS_DEPTH; k++)
        begin
            x  = (HALFPI_Q30 * 64'(k) + 64'(COS_DEPTH / 2)) / 64'(COS_DEPTH);
            x2 = (x * x + (Q30_ONE >> 1)) >> 30;
            t  = Q30_ONE;
            for (int s = 0; s < 7; s++)
            begin
                p = (x2 * t + (Q30_ONE >> 1)) >> 30;
                d = (p + SERIES_DIV[s] / 2) / SERIES_DIV[s];
                t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
            end
            rom[k] = COS_DBITS'((t + 64'd8192) >> 14);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ----- rtl/core/wcau_if.sv -----
// Sample input channel.
interface wcau_in_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [wcau_pkg::SAMPLE_BITS-1:0]       sample_in;
    modport source (output valid, sample_in, input ready);
    modport sink (input valid, sample_in, output ready);
endinterface

// Result channel.
interface wcau_out_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [wcau_pkg::SAMPLE_BITS-1:0]       windowed_sample;
    logic signed [wcau_pkg::COEF_BITS-1:0]         coefficient;
    logic                                          frame_end;
    logic                                          kind_error;
    modport source (output valid, windowed_sample, coefficient, frame_end, kind_error,
                    input ready);
    modport sink (input valid, windowed_sample, coefficient, frame_end, kind_error,
                  output ready);
endinterface

// Configuration write channel.
interface wcau_cfg_if;
    logic                                          valid;
    logic                                          ready;
    logic [1:0]                                    index;
    logic [wcau_pkg::COEF_BITS-1:0]                data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/wcau_cfg.sv -----
module wcau_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    wcau_cfg_if.sink              cfg,
    output wcau_pkg::cfg_state_t  state
);

    logic [3:0]                            kind_reg;
    logic [wcau_pkg::LEN_BITS-1:0]         len_reg;
    logic signed [wcau_pkg::COEF_BITS-1:0] alpha_reg;
    logic [31:0]                           step_reg;
    logic [wcau_pkg::COEF_BITS-1:0]        slope_reg;
    logic                                  restart_reg;

    // Shared restoring divider, one quotient bit per cycle.
    logic [5:0]                            cnt_reg;
    logic [32:0]                           num_reg;
    logic [wcau_pkg::LEN_BITS-1:0]         rem_reg;
    logic [wcau_pkg::LEN_BITS-1:0]         den_reg;
    logic                                  is_step_reg;
    logic                                  slope_pend_reg;

    logic                                  wr;
    logic [wcau_pkg::LEN_BITS-1:0]         len_sat;
    logic [wcau_pkg::LEN_BITS:0]           trial;
    logic                                  ge;
    logic [32:0]                           num_next;
    logic [wcau_pkg::LEN_BITS-1:0]         rem_next;
    logic [wcau_pkg::LEN_BITS-1:0]         slope_den;
    logic                                  busy;

    assign busy      = (cnt_reg != 6'd0) || slope_pend_reg;
    assign cfg.ready = !busy;
    assign wr        = cfg.valid && cfg.ready;

    // Clamp of the written frame length.
    always_comb
    begin
        if (cfg.data[12:0] < 13'(wcau_pkg::MIN_FRAME))
            len_sat = 13'(wcau_pkg::MIN_FRAME);
        else if (cfg.data[12:0] > 13'(wcau_pkg::MAX_FRAME))
            len_sat = 13'(wcau_pkg::MAX_FRAME);
        else
            len_sat = cfg.data[12:0];
    end

    // Divisor of the triangle slope for the current kind and length.
    assign slope_den = (kind_reg == wcau_pkg::KIND_TRI_ZERO) ? len_reg - 13'd2 : len_reg;

    // One divider step.
    always_comb
    begin
        trial    = {rem_reg, num_reg[32]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? 13'(trial - {1'b0, den_reg}) : trial[12:0];
        num_next = {num_reg[31:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= wcau_pkg::RST_KIND;
            len_reg        <= wcau_pkg::RST_LEN;
            alpha_reg      <= wcau_pkg::RST_ALPHA;
            step_reg       <= wcau_pkg::RST_STEP;
            slope_reg      <= wcau_pkg::RST_SLOPE;
            restart_reg    <= 1'b0;
            cnt_reg        <= 6'd0;
            is_step_reg    <= 1'b0;
            slope_pend_reg <= 1'b0;
            num_reg        <= '0;
            rem_reg        <= '0;
            den_reg        <= '0;
        end
        else
        begin
            restart_reg <= 1'b0;
            if (wr)
            begin
                unique case (cfg.index)
                    wcau_pkg::CFG_KIND:
                    begin
                        kind_reg       <= cfg.data[3:0];
                        slope_pend_reg <= 1'b1;
                    end
                    wcau_pkg::CFG_LEN:
                    begin
                        len_reg        <= len_sat;
                        restart_reg    <= 1'b1;
                        slope_pend_reg <= 1'b1;
                        // Phase step: (2^32 + N/2) / N.
                        cnt_reg        <= 6'd33;
                        is_step_reg    <= 1'b1;
                        num_reg        <= {1'b1, 20'd0, len_sat[12:1]};
                        rem_reg        <= '0;
                        den_reg        <= len_sat;
                    end
                    wcau_pkg::CFG_ALPHA:
                        alpha_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            else if (cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                num_reg <= num_next;
                rem_reg <= rem_next;
                if (cnt_reg == 6'd1)
                begin
                    if (is_step_reg)
                        step_reg <= num_next[31:0];
                    else
                        slope_reg <= num_next[17:0];
                end
            end
            else if (slope_pend_reg)
            begin
                // Triangle slope: (2^17 + d/2) / d, zero for a zero divisor.
                slope_pend_reg <= 1'b0;
                if (slope_den == 13'd0)
                    slope_reg <= '0;
                else
                begin
                    cnt_reg     <= 6'd33;
                    is_step_reg <= 1'b0;
                    num_reg     <= 33'(18'd131072 + 18'(slope_den[12:1]));
                    rem_reg     <= '0;
                    den_reg     <= slope_den;
                end
            end
        end
    end

    assign state.kind    = kind_reg;
    assign state.len     = len_reg;
    assign state.alpha   = alpha_reg;
    assign state.step    = step_reg;
    assign state.slope   = slope_reg;
    assign state.busy    = busy;
    assign state.restart = restart_reg;

endmodule

// ----- rtl/core/wcau_front.sv -----
module wcau_front (
    input  logic                  clk,
    input  logic                  rst_n,
    wcau_in_if.sink               samples,
    input  wcau_pkg::cfg_state_t  cfg_state,
    input  logic                  q_full,
    output logic                  push,
    output wcau_pkg::item_t       push_item
);

    logic [wcau_pkg::POS_BITS-1:0] pos_reg;
    logic [31:0]                   phase_reg;

    logic [wcau_pkg::POS_BITS-1:0] half;
    logic                          fend;

    assign samples.ready = !cfg_state.busy && !cfg_state.restart && !q_full;
    assign push          = samples.valid && samples.ready;

    assign half = cfg_state.len[12:1];
    assign fend = (13'({1'b0, pos_reg}) + 13'd1) >= cfg_state.len;

    // Classify the position for the triangle windows and build the queue word.
    always_comb
    begin
        push_item.sample    = samples.sample_in;
        push_item.phase     = phase_reg;
        push_item.frame_end = fend;
        if (pos_reg < half)
        begin
            push_item.tri_region = wcau_pkg::TRI_RISE;
            push_item.tri_mul    = {1'b0, pos_reg} +
                                   13'(cfg_state.kind == wcau_pkg::KIND_TRI_NZ);
        end
        else if ({1'b0, pos_reg} < {half, 1'b0})
        begin
            push_item.tri_region = wcau_pkg::TRI_FALL;
            push_item.tri_mul    = {1'b0, pos_reg - half};
        end
        else
        begin
            push_item.tri_region = wcau_pkg::TRI_ZERO;
            push_item.tri_mul    = '0;
        end
    end

    // Position counter and phase accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= '0;
        end
        else if (cfg_state.restart)
        begin
            pos_reg   <= '0;
            phase_reg <= '0;
        end
        else if (push)
        begin
            if (fend)
            begin
                pos_reg   <= '0;
                phase_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_reg + 12'd1;
                phase_reg <= phase_reg + cfg_state.step;
            end
        end
    end

endmodule

// ----- rtl/core/wcau_queue.sv -----
module wcau_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wcau_pkg::item_t  push_item,
    input  logic             pop,
    output wcau_pkg::item_t  head,
    output logic             empty,
    output logic             full
);

    wcau_pkg::item_t slot_reg [0:1];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    // Two-word queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- rtl/core/wcau_back.sv -----
module wcau_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wcau_pkg::cfg_state_t  cfg_state,
    input  wcau_pkg::item_t       head,
    input  logic                  q_empty,
    output logic                  pop,
    wcau_out_if.source            results
);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_C1   = 7'b0000010,
        B_C2   = 7'b0000100,
        B_C3   = 7'b0001000,
        B_COEF = 7'b0010000,
        B_MUL  = 7'b0100000,
        B_OUT  = 7'b1000000
    } back_state_t;

    back_state_t                           state_reg;
    back_state_t                           state_next;
    wcau_pkg::item_t                       item_reg;
    logic [wcau_pkg::COS_DBITS-1:0]        rom_data_reg;
    logic                                  rom_neg_reg;
    logic signed [39:0]                    acc_reg;
    logic [30:0]                           tri_prod_reg;
    logic signed [wcau_pkg::COEF_BITS-1:0] coef_reg;
    logic                                  err_reg;
    logic signed [33:0]                    prod_reg;
    logic                                  out_valid_reg;
    logic signed [wcau_pkg::SAMPLE_BITS-1:0] out_y_reg;
    logic signed [wcau_pkg::COEF_BITS-1:0] out_coef_reg;
    logic                                  out_fend_reg;
    logic                                  out_err_reg;

    logic [31:0]                           ph_sel;
    logic [10:0]                           cos_idx;
    logic [wcau_pkg::COS_ABITS-1:0]        rom_addr;
    logic                                  rom_neg;
    logic signed [19:0]                    a0;
    logic signed [19:0]                    m1;
    logic signed [19:0]                    m2;
    logic signed [19:0]                    m3;
    logic signed [19:0]                    m_sel;
    logic signed [17:0]                    c_val;
    logic signed [37:0]                    term;
    logic signed [39:0]                    acc_rnd;
    logic signed [23:0]                    acc_q16;
    logic signed [32:0]                    tri_val;
    logic signed [wcau_pkg::COEF_BITS-1:0] cos_coef;
    logic signed [wcau_pkg::COEF_BITS-1:0] tri_coef;
    logic signed [wcau_pkg::COEF_BITS-1:0] coef_next;
    logic                                  err_next;
    logic signed [33:0]                    prod_rnd;
    logic signed [17:0]                    y_q;
    logic signed [wcau_pkg::SAMPLE_BITS-1:0] y_sat;
    logic                                  out_free;

    assign out_free = !out_valid_reg || results.ready;
    assign pop      = (state_reg == B_IDLE) && !q_empty;

    // Sequencer: three cosine reads, coefficient, product, result.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_empty) state_next = B_C1;
            B_C1:   state_next = B_C2;
            B_C2:   state_next = B_C3;
            B_C3:   state_next = B_COEF;
            B_COEF: state_next = B_MUL;
            B_MUL:  state_next = B_OUT;
            B_OUT:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Phase of the next read: phase, twice phase, three times phase.
    always_comb
    begin
        unique case (state_reg)
            B_IDLE:  ph_sel = head.phase;
            B_C1:    ph_sel = {item_reg.phase[30:0], 1'b0};
            B_C2:    ph_sel = item_reg.phase + {item_reg.phase[30:0], 1'b0};
            default: ph_sel = item_reg.phase;
        endcase
        cos_idx  = 11'(ph_sel[29:20]) + 11'(ph_sel[19]);
        rom_addr = ph_sel[30] ? 11'(wcau_pkg::COS_DEPTH) - cos_idx : cos_idx;
        rom_neg  = ph_sel[31] ^ ph_sel[30];
    end

    // Quarter-wave cosine table with registered read.
    always_ff @(posedge clk)
    begin
        rom_data_reg <= wcau_pkg::COS_ROM[rom_addr];
        rom_neg_reg  <= rom_neg;
    end

    // Cosine-sum weights of the configured kind.
    always_comb
    begin
        a0 = '0;
        m1 = '0;
        m2 = '0;
        m3 = '0;
        case (cfg_state.kind)
            wcau_pkg::KIND_HANN:
            begin
                a0 = wcau_pkg::Q_HALF;
                m1 = -wcau_pkg::Q_HALF;
            end
            wcau_pkg::KIND_HAMMING:
            begin
                a0 = wcau_pkg::Q_HAM_A0;
                m1 = -wcau_pkg::Q_HAM_A1;
            end
            wcau_pkg::KIND_GENCOS:
            begin
                a0 = 20'(cfg_state.alpha);
                m1 = 20'(cfg_state.alpha) - wcau_pkg::Q_ONE;
            end
            wcau_pkg::KIND_BLACKMAN:
            begin
                a0 = wcau_pkg::Q_BLK_A0;
                m1 = -wcau_pkg::Q_HALF;
                m2 = wcau_pkg::Q_BLK_A2;
            end
            wcau_pkg::KIND_BHARRIS:
            begin
                a0 = wcau_pkg::Q_BH_A0;
                m1 = -wcau_pkg::Q_BH_A1;
                m2 = wcau_pkg::Q_BH_A2;
                m3 = -wcau_pkg::Q_BH_A3;
            end
            wcau_pkg::KIND_FLAT:
            begin
                a0 = wcau_pkg::Q_FT_A0;
                m1 = -wcau_pkg::Q_FT_A1;
                m2 = wcau_pkg::Q_FT_A2;
            end
            default:
            begin
            end
        endcase
    end

    // One weighted cosine term per cycle.
    always_comb
    begin
        unique case (state_reg)
            B_C1:    m_sel = m1;
            B_C2:    m_sel = m2;
            B_C3:    m_sel = m3;
            default: m_sel = '0;
        endcase
        c_val = rom_neg_reg ? -$signed({1'b0, rom_data_reg}) : $signed({1'b0, rom_data_reg});
        term  = m_sel * c_val;
    end

    // Coefficient: rounded cosine sum, triangle, rectangle or invalid.
    always_comb
    begin
        acc_rnd = acc_reg + 40'sd32768;
        acc_q16 = 24'(acc_rnd >>> 16);
        if (acc_q16 > 24'sd131071)
            cos_coef = 18'sd131071;
        else if (acc_q16 < -24'sd131072)
            cos_coef = -18'sd131072;
        else
            cos_coef = acc_q16[17:0];

        case (item_reg.tri_region)
            wcau_pkg::TRI_RISE: tri_val = $signed({2'b00, tri_prod_reg});
            wcau_pkg::TRI_FALL: tri_val = 33'sd65536 - $signed({2'b00, tri_prod_reg});
            default:            tri_val = '0;
        endcase
        if (tri_val > 33'sd131071)
            tri_coef = 18'sd131071;
        else if (tri_val < -33'sd131072)
            tri_coef = -18'sd131072;
        else
            tri_coef = tri_val[17:0];

        err_next = 1'b0;
        case (cfg_state.kind) inside
            wcau_pkg::KIND_HANN, wcau_pkg::KIND_HAMMING, wcau_pkg::KIND_GENCOS,
            wcau_pkg::KIND_BLACKMAN, wcau_pkg::KIND_BHARRIS, wcau_pkg::KIND_FLAT:
                coef_next = cos_coef;
            wcau_pkg::KIND_TRI_ZERO, wcau_pkg::KIND_TRI_NZ:
                coef_next = tri_coef;
            wcau_pkg::KIND_RECT:
                coef_next = 18'sd65536;
            default:
            begin
                coef_next = '0;
                err_next  = 1'b1;
            end
        endcase
    end

    // Rounding and saturation of the windowed sample.
    always_comb
    begin
        prod_rnd = prod_reg + 34'sd32768;
        y_q      = 18'(prod_rnd >>> 16);
        if (err_reg)
            y_sat = '0;
        else if (y_q > 18'sd32767)
            y_sat = 16'sh7fff;
        else if (y_q < -18'sd32768)
            y_sat = 16'sh8000;
        else
            y_sat = y_q[15:0];
    end

    // Working registers of the back end.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                item_reg <= head;
                acc_reg  <= '0;
            end
            B_C1:
            begin
                acc_reg      <= {{4{a0[19]}}, a0, 16'd0} + {{2{term[37]}}, term};
                tri_prod_reg <= item_reg.tri_mul * cfg_state.slope;
            end
            B_C2, B_C3:
                acc_reg <= acc_reg + {{2{term[37]}}, term};
            B_COEF:
            begin
                coef_reg <= coef_next;
                err_reg  <= err_next;
            end
            B_MUL:
                prod_reg <= item_reg.sample * coef_reg;
            default:
            begin
            end
        endcase
    end

    // Result register towards the output channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == B_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == B_OUT) && out_free)
        begin
            out_y_reg    <= y_sat;
            out_coef_reg <= coef_reg;
            out_fend_reg <= item_reg.frame_end;
            out_err_reg  <= err_reg;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.windowed_sample = out_y_reg;
    assign results.coefficient     = out_coef_reg;
    assign results.frame_end       = out_fend_reg;
    assign results.kind_error      = out_err_reg;

endmodule

// ----- rtl/core/window_coefficient_applier_unit.sv -----
// Periodic window applier ahead of an FFT. Each accepted sample is given its
// position in a frame of frame_length samples and multiplied by the window
// coefficient of that position; the result word carries the rounded and
// saturated product, the Q2.16 coefficient, a frame-end mark and an error flag
// for an invalid window kind. A front end numbers and classifies samples and
// feeds a two-word queue; the back end reads the quarter-wave cosine table
// three times (once per cycle, one read port), accumulates the weighted
// cosine sum and forms the product, and takes the next sample from the queue
// only when it is through with the last one. A result waiting at the
// output holds the back end; the front end goes on taking samples until the
// queue is full. Writing frame_length restarts the frame and re-derives the
// phase step and triangle slope in a serial divider; writing window_kind
// re-derives the slope. During that time neither samples nor further writes
// are taken.
module window_coefficient_applier_unit (
    input  logic         clk,
    input  logic         rst_n,
    wcau_cfg_if.sink     cfg,
    wcau_in_if.sink      samples,
    wcau_out_if.source   results
);

    wcau_pkg::cfg_state_t cfg_state;
    wcau_pkg::item_t      push_item;
    wcau_pkg::item_t      head;
    logic                 push;
    logic                 pop;
    logic                 q_empty;
    logic                 q_full;

    // Configuration registers and derived state.
    wcau_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .state (cfg_state)
    );

    // Position and phase tracking.
    wcau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg_state (cfg_state),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Queue between the two ends.
    wcau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Coefficient and product.
    wcau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_state (cfg_state),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .results   (results)
    );

endmodule
